// File: design/hpd_pkg.sv
// ----------------------------------------------------------------------------
// hpd_pkg
// Shared types, codes and sizes of the hold-and-modify pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hpd_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_ADDR_W      = $clog2(PALETTE_ENTRIES);
    localparam int CODE_W          = 8;
    localparam int CHAN_W          = 8;
    localparam int COLOUR_W        = 3 * CHAN_W;
    localparam int MODE_W          = 2;

    // Stream word sizes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    // decode_mode codes; the unused code behaves as indexed
    localparam logic [MODE_W-1:0] MODE_INDEXED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HAM6    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HAM8    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

    // hold-and-modify control codes
    localparam logic [1:0] SEL_LOAD  = 2'd0;
    localparam logic [1:0] SEL_BLUE  = 2'd1;
    localparam logic [1:0] SEL_RED   = 2'd2;
    localparam logic [1:0] SEL_GREEN = 2'd3;

    // tuser codes
    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // Bound for palette index checks, one bit wider than a code
    localparam logic [CODE_W:0] PAL_LIMIT = (CODE_W + 1)'(PALETTE_ENTRIES);

    // red in the top byte, blue in the bottom byte
    typedef logic [COLOUR_W-1:0] colour_t;

    // Decode word travelling alongside the palette read
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              line_start;
        logic              in_range;
    } pix_item_t;

endpackage

`default_nettype wire

// File: design/hpd_ram.sv
// ----------------------------------------------------------------------------
// hpd_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module hpd_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // Read data holds while rd_en is low
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/hpd_colour_calc.sv
// ----------------------------------------------------------------------------
// hpd_colour_calc
// Applies one pixel code to the held colour and picks the output colour.
// ----------------------------------------------------------------------------
`default_nettype none

module hpd_colour_calc (
    input  wire logic [hpd_pkg::MODE_W-1:0] mode,
    input  wire hpd_pkg::pix_item_t         item,
    input  wire hpd_pkg::colour_t           entry_data,
    input  wire hpd_pkg::colour_t           held,
    output hpd_pkg::colour_t                colour,
    output hpd_pkg::colour_t                held_next
);

    import hpd_pkg::*;

    colour_t           base;
    colour_t           entry;
    colour_t           ham;
    logic [1:0]        sel;
    logic [CHAN_W-1:0] val;
    logic              is_ham;

    always_comb
    begin
        base   = item.line_start ? '0 : held;
        entry  = item.in_range ? entry_data : '0;
        is_ham = (mode == MODE_HAM6) || (mode == MODE_HAM8);

        if (mode == MODE_HAM6)
        begin
            sel = item.code[5:4];
            val = {item.code[3:0], 4'b0000};
        end
        else
        begin
            sel = item.code[7:6];
            val = {item.code[5:0], 2'b00};
        end

        case (sel)
            SEL_LOAD:  ham = entry;
            SEL_BLUE:  ham = {base[23:8], val};
            SEL_RED:   ham = {val, base[15:0]};
            SEL_GREEN: ham = {base[23:16], val, base[7:0]};
            default:   ham = entry;
        endcase

        if (is_ham)
        begin
            colour    = ham;
            held_next = ham;
        end
        else
        begin
            // Indexed: held colour only sees the line-start clear
            colour    = entry;
            held_next = base;
        end
    end

endmodule

`default_nettype wire

// File: design/ham_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// ham_pixel_decoder_unit
// Pixel code to 24-bit RGB decoder: indexed palette, HAM6 and HAM8.
//
// Takes one word per clock. A write word (tuser high) loads one palette entry
// and yields no output; a decode word yields one RGB word. The palette read
// is registered when the word is accepted, and the code is then applied to
// the held colour into the output register once that register is free. The
// held colour loop closes in that second stage, so back-to-back HAM pixels
// run at one per clock; the input stalls only while both stages are full and
// the sink holds tready low. The palette is not cleared at reset; an entry
// must be written before a pixel reads it. decode_mode must be written only
// while the unit is idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module ham_pixel_decoder_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            cfg_wr_en,
    input  wire logic [hpd_pkg::MODE_W-1:0]      cfg_wr_data,

    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // line_start[0], pixel_code[8:1], entry_index[16:9], entry_red[24:17],
    // entry_green[32:25], entry_blue[40:33], zero[47:41]
    input  wire logic [hpd_pkg::S_TDATA_W-1:0]   s_tdata,
    // op[0]
    input  wire logic                            s_tuser,

    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic      [hpd_pkg::M_TDATA_W-1:0]   m_tdata
);

    import hpd_pkg::*;

    logic [MODE_W-1:0]     decode_mode_reg;

    logic                  s1_valid_reg, s1_valid_next;
    pix_item_t             s1_item_reg;
    logic                  out_valid_reg, out_valid_next;
    colour_t               out_colour_reg;
    colour_t               held_reg;

    logic                  accept;
    logic                  out_free;
    logic                  s1_move;
    logic                  wr_en;
    logic                  rd_en;
    logic [CODE_W-1:0]     in_code;
    logic [CODE_W-1:0]     in_index;
    logic [CODE_W-1:0]     rd_index;
    colour_t               wr_colour;
    colour_t               rd_data;
    colour_t               calc_colour;
    colour_t               calc_held;
    pix_item_t             in_item;

    assign in_code   = s_tdata[8:1];
    assign in_index  = s_tdata[16:9];
    assign wr_colour = {s_tdata[24:17], s_tdata[32:25], s_tdata[40:33]};

    assign out_free = !out_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    assign wr_en = accept && (s_tuser == OP_WRITE) && ({1'b0, in_index} < PAL_LIMIT);
    assign rd_en = accept && (s_tuser == OP_DECODE);

    // Palette index as seen by the current mode
    always_comb
    begin
        case (decode_mode_reg)
            MODE_HAM6: rd_index = {4'b0000, in_code[3:0]};
            MODE_HAM8: rd_index = {2'b00, in_code[5:0]};
            default:   rd_index = in_code;
        endcase
        in_item.code       = in_code;
        in_item.line_start = s_tdata[0];
        in_item.in_range   = ({1'b0, rd_index} < PAL_LIMIT);
    end

    hpd_ram #(
        .DATA_W (COLOUR_W),
        .DEPTH  (PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (in_index[PAL_ADDR_W-1:0]),
        .wr_data (wr_colour),
        .rd_en   (rd_en),
        .rd_addr (rd_index[PAL_ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    hpd_colour_calc u_calc (
        .mode       (decode_mode_reg),
        .item       (s1_item_reg),
        .entry_data (rd_data),
        .held       (held_reg),
        .colour     (calc_colour),
        .held_next  (calc_held)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rd_en)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg <= MODE_INDEXED;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            held_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                decode_mode_reg <= cfg_wr_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_move)
            begin
                held_reg <= calc_held;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_move)
        begin
            out_colour_reg <= calc_colour;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_colour_reg[7:0], out_colour_reg[15:8], out_colour_reg[23:16]};

endmodule

`default_nettype wire

// File: verif/tb_ham_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_ham_pixel_decoder_unit
// Self-checking bench for the indexed / HAM6 / HAM8 pixel decoder. A short
// directed table covers each decode mode, every hold-and-modify action, line
// start and the unused mode code. Random phases then stream palette writes and
// pixel rows under random source gaps and sink stalls. Directed output words
// are checked against the table, others against a shadow palette and held colour.
// ----------------------------------------------------------------------------

module tb_ham_pixel_decoder_unit;

    import hpd_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 60;

    typedef enum logic { ROW_WORD, ROW_MODE } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [MODE_W-1:0] mode;
        logic              op;
        logic              ls;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] idx;
        colour_t           rgb;
        bit                typed;
        colour_t           want;
    } stim_row_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [MODE_W-1:0]     cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic                  s_tuser     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // shadow state of the decoder
    colour_t               palette_shadow [PALETTE_ENTRIES];
    bit                    palette_written [PALETTE_ENTRIES];
    colour_t               held_rgb    = '0;
    logic [MODE_W-1:0]     mode_shadow = MODE_INDEXED;

    colour_t               pending_rgb [$];
    stim_row_t             dir_rows [$];

    int                    mismatches    = 0;
    int                    pixels_sent   = 0;
    int                    writes_sent   = 0;
    int                    pixels_seen   = 0;
    int                    mode_writes   = 0;
    int                    cycle_count   = 0;
    int                    ready_left    = 0;
    int                    sink_roll;
    bit                    no_idle       = 1'b0;

    ham_pixel_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Which palette entry a decode word reads under the current mode, if any
    function automatic logic palette_ref(input logic [CODE_W-1:0] code,
                                         output logic [CODE_W-1:0] pidx);
        case (mode_shadow)
            MODE_HAM6:
            begin
                pidx = {4'b0, code[3:0]};
                return code[5:4] == SEL_LOAD;
            end
            MODE_HAM8:
            begin
                pidx = {2'b0, code[5:0]};
                return code[7:6] == SEL_LOAD;
            end
            default:
            begin
                pidx = code;
                return 1'b1;
            end
        endcase
    endfunction

    // Applies one accepted word to the shadow state; col is the pixel colour
    task automatic decode_pixel(input logic op, input logic ls,
                                input logic [CODE_W-1:0] code,
                                input logic [CODE_W-1:0] idx, input colour_t rgb,
                                output logic has_res, output colour_t col);
        logic [CODE_W-1:0] pidx;
        logic [1:0]        sel;
        logic [CHAN_W-1:0] val;
        logic              reads;
        has_res = 1'b0;
        col     = '0;
        if (op == OP_WRITE)
        begin
            if (int'(idx) < PALETTE_ENTRIES)
            begin
                palette_shadow[idx]  = rgb;
                palette_written[idx] = 1'b1;
            end
            return;
        end
        has_res = 1'b1;
        if (ls)
            held_rgb = '0;
        reads = palette_ref(code, pidx);
        if (mode_shadow == MODE_HAM6 || mode_shadow == MODE_HAM8)
        begin
            if (mode_shadow == MODE_HAM6)
            begin
                sel = code[5:4];
                val = {code[3:0], 4'b0};
            end
            else
            begin
                sel = code[7:6];
                val = {code[5:0], 2'b0};
            end
            case (sel)
                SEL_LOAD:  held_rgb = (int'(pidx) < PALETTE_ENTRIES) ?
                                      palette_shadow[pidx] : '0;
                SEL_BLUE:  held_rgb[7:0]   = val;
                SEL_RED:   held_rgb[23:16] = val;
                default:   held_rgb[15:8]  = val;
            endcase
            col = held_rgb;
        end
        else
        begin
            col = (int'(pidx) < PALETTE_ENTRIES) ? palette_shadow[pidx] : '0;
        end
    endtask

    function automatic int next_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %02h want %02h (output word %0d)",
                 what, got, want, pixels_seen);
        mismatches++;
    endtask

    // Drives one input word and waits for it to be taken
    task automatic send_word(input logic op, input logic ls,
                             input logic [CODE_W-1:0] code,
                             input logic [CODE_W-1:0] idx, input colour_t rgb,
                             input int gap, input bit typed, input colour_t want);
        logic    has_res;
        colour_t col;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, rgb[7:0], rgb[15:8], rgb[23:16], idx, code, ls};
        do
            @(posedge clk);
        while (!s_tready);
        decode_pixel(op, ls, code, idx, rgb, has_res, col);
        if (has_res)
        begin
            pending_rgb.push_back(typed ? want : col);
            pixels_sent++;
        end
        else
        begin
            writes_sent++;
        end
    endtask

    // Mode changes only with the pipe drained
    task automatic set_mode(input logic [MODE_W-1:0] m);
        s_tvalid <= 1'b0;
        while (pending_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mode_shadow = m;
        mode_writes++;
    endtask

    task automatic add_word(input logic op, input logic ls,
                            input logic [CODE_W-1:0] code,
                            input logic [CODE_W-1:0] idx, input colour_t rgb,
                            input bit typed, input colour_t want);
        stim_row_t row;
        row.kind  = ROW_WORD;
        row.mode  = MODE_INDEXED;
        row.op    = op;
        row.ls    = ls;
        row.code  = code;
        row.idx   = idx;
        row.rgb   = rgb;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    task automatic add_mode(input logic [MODE_W-1:0] m);
        stim_row_t row;
        row.kind  = ROW_MODE;
        row.mode  = m;
        row.op    = OP_DECODE;
        row.ls    = 1'b0;
        row.code  = '0;
        row.idx   = '0;
        row.rgb   = '0;
        row.typed = 1'b0;
        row.want  = '0;
        dir_rows.push_back(row);
    endtask

    // Sink: random ready pattern, mostly short stalls, some long, some open runs
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            sink_roll = $urandom_range(0, 99);
            if (sink_roll < 45)
            begin
                m_tready   <= 1'b1;
                ready_left = $urandom_range(1, 16);
            end
            else if (sink_roll < 80)
            begin
                m_tready   <= 1'b0;
                ready_left = $urandom_range(1, 3);
            end
            else if (sink_roll < 92)
            begin
                m_tready   <= 1'b0;
                ready_left = $urandom_range(4, 30);
            end
            else
            begin
                m_tready   <= 1'b1;
                ready_left = $urandom_range(40, 150);
            end
        end
        else
        begin
            ready_left--;
        end
    end

    // Output checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_rgb.size() == 0)
            begin
                report_mismatch("output word with nothing pending", int'(m_tdata), 0);
            end
            else
            begin
                colour_t want;
                want = pending_rgb.pop_front();
                if (m_tdata[7:0] !== want[23:16])
                    report_mismatch("red", int'(m_tdata[7:0]), int'(want[23:16]));
                if (m_tdata[15:8] !== want[15:8])
                    report_mismatch("green", int'(m_tdata[15:8]), int'(want[15:8]));
                if (m_tdata[23:16] !== want[7:0])
                    report_mismatch("blue", int'(m_tdata[23:16]), int'(want[7:0]));
            end
            pixels_seen++;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d words still pending",
                 cycle_count, pending_rgb.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : main
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] pidx;
        logic              ls;
        int                roll;
        int                line_left;

        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            palette_shadow[i]  = '0;
            palette_written[i] = 1'b0;
        end

        // indexed mode straight out of reset; write fields are ignored on decode
        add_word(OP_WRITE,  1'b1, 8'hff, 8'h00, 24'h000000, 1'b0, '0);
        add_word(OP_WRITE,  1'b0, 8'h00, 8'hff, 24'hffffff, 1'b0, '0);
        add_word(OP_WRITE,  1'b0, 8'h00, 8'h0f, 24'h123456, 1'b0, '0);
        add_word(OP_WRITE,  1'b0, 8'h00, 8'h3f, 24'ha55ac3, 1'b0, '0);
        add_word(OP_WRITE,  1'b0, 8'h00, 8'h80, 24'h010203, 1'b0, '0);
        add_word(OP_DECODE, 1'b0, 8'h00, 8'hff, 24'hffffff, 1'b1, 24'h000000);
        add_word(OP_DECODE, 1'b0, 8'hff, 8'h00, 24'h000000, 1'b1, 24'hffffff);
        add_word(OP_DECODE, 1'b1, 8'h80, 8'h00, 24'h000000, 1'b1, 24'h010203);
        // HAM6: blue, red, green, load, load with ignored top bits, line start
        add_mode(MODE_HAM6);
        add_word(OP_DECODE, 1'b1, 8'h1f, 8'h00, 24'h000000, 1'b1, 24'h0000f0);
        add_word(OP_DECODE, 1'b0, 8'h2a, 8'h00, 24'h000000, 1'b1, 24'ha000f0);
        add_word(OP_DECODE, 1'b0, 8'h35, 8'h00, 24'h000000, 1'b1, 24'ha050f0);
        add_word(OP_DECODE, 1'b0, 8'h0f, 8'h00, 24'h000000, 1'b1, 24'h123456);
        add_word(OP_DECODE, 1'b0, 8'hcf, 8'h00, 24'h000000, 1'b1, 24'h123456);
        add_word(OP_DECODE, 1'b1, 8'h31, 8'h00, 24'h000000, 1'b1, 24'h001000);
        // HAM8
        add_mode(MODE_HAM8);
        add_word(OP_DECODE, 1'b1, 8'h7f, 8'h00, 24'h000000, 1'b1, 24'h0000fc);
        add_word(OP_DECODE, 1'b0, 8'hbf, 8'h00, 24'h000000, 1'b1, 24'hfc00fc);
        add_word(OP_DECODE, 1'b0, 8'hff, 8'h00, 24'h000000, 1'b1, 24'hfcfcfc);
        add_word(OP_DECODE, 1'b0, 8'h3f, 8'h00, 24'h000000, 1'b1, 24'ha55ac3);
        add_word(OP_DECODE, 1'b0, 8'h41, 8'h00, 24'h000000, 1'b1, 24'ha55a04);
        add_word(OP_DECODE, 1'b1, 8'h00, 8'h00, 24'h000000, 1'b1, 24'h000000);
        // unused mode code decodes as indexed
        add_mode(MODE_SPARE);
        add_word(OP_DECODE, 1'b0, 8'hff, 8'h00, 24'h000000, 1'b1, 24'hffffff);
        add_word(OP_DECODE, 1'b0, 8'h3f, 8'h00, 24'h000000, 1'b1, 24'ha55ac3);
        add_word(OP_WRITE,  1'b0, 8'h00, 8'hff, 24'h000000, 1'b0, '0);
        add_word(OP_DECODE, 1'b0, 8'hff, 8'h00, 24'h000000, 1'b1, 24'h000000);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_MODE)
                set_mode(dir_rows[i].mode);
            else
                send_word(dir_rows[i].op, dir_rows[i].ls, dir_rows[i].code,
                          dir_rows[i].idx, dir_rows[i].rgb, next_gap(),
                          dir_rows[i].typed, dir_rows[i].want);
        end

        // random phases: pixel rows with line starts, palette writes mixed in
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            set_mode(phase < 4 ? MODE_W'(phase) : MODE_W'($urandom_range(0, 3)));
            no_idle   = ($urandom_range(0, 3) == 0);
            line_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                code = CODE_W'($urandom_range(0, 255));
                if (roll < 12)
                begin
                    send_word(OP_WRITE, 1'($urandom_range(0, 1)), code,
                              CODE_W'($urandom_range(0, 255)), colour_t'($urandom),
                              next_gap(), 1'b0, '0);
                end
                else
                begin
                    if (line_left == 0)
                    begin
                        ls        = 1'b1;
                        line_left = $urandom_range(1, 40);
                    end
                    else
                    begin
                        ls = (roll < 16) ? 1'($urandom_range(0, 1)) : 1'b0;
                    end
                    line_left--;
                    // load the entry first if this pixel would read a blank one
                    if (palette_ref(code, pidx) && !palette_written[pidx])
                        send_word(OP_WRITE, 1'($urandom_range(0, 1)),
                                  CODE_W'($urandom_range(0, 255)), pidx,
                                  colour_t'($urandom), next_gap(), 1'b0, '0);
                    send_word(OP_DECODE, ls, code, CODE_W'($urandom_range(0, 255)),
                              colour_t'($urandom), next_gap(), 1'b0, '0);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES * 2) @(posedge clk);

        $display("Covered %0d palette writes and %0d pixel decodes over %0d mode settings,",
                 writes_sent, pixels_sent, mode_writes);
        $display("all modes incl. the unused code; %0d output words checked, %0d mismatches",
                 pixels_seen, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: ham_pixel_decoder_unit.f
design/hpd_pkg.sv
design/hpd_ram.sv
design/hpd_colour_calc.sv
design/ham_pixel_decoder_unit.sv
verif/tb_ham_pixel_decoder_unit.sv
